### rtl/ltc_pkg.sv
// ----------------------------------------------------------------------------
// ltc_pkg
// Shared types and key ROM lookups for the Latin to Cyrillic transliterator.
// ----------------------------------------------------------------------------
`default_nettype none

package ltc_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned CP_W   = 11;
	localparam int unsigned LEN_W  = 2;

	// Result action codes
	typedef enum logic [1:0] {
		ACT_NONE    = 2'd0,
		ACT_ADD     = 2'd1,
		ACT_REPLACE = 2'd2
	} action_t;

	typedef logic [BYTE_W-1:0] byte_t;
	typedef logic [CP_W-1:0]   cp_t;

	// Single-byte keys; zero when the byte is no key
	function automatic cp_t lookup1(input byte_t c);
		cp_t cp;
		case (c)
			"a":  cp = 11'h430;
			"b":  cp = 11'h431;
			"c":  cp = 11'h446;
			"d":  cp = 11'h434;
			"e":  cp = 11'h435;
			"f":  cp = 11'h444;
			"g":  cp = 11'h433;
			"h":  cp = 11'h445;
			"i":  cp = 11'h438;
			"j":  cp = 11'h439;
			"k":  cp = 11'h43A;
			"l":  cp = 11'h43B;
			"m":  cp = 11'h43C;
			"n":  cp = 11'h43D;
			"o":  cp = 11'h43E;
			"p":  cp = 11'h43F;
			"q":  cp = 11'h44F;
			"r":  cp = 11'h440;
			"s":  cp = 11'h441;
			"t":  cp = 11'h442;
			"u":  cp = 11'h443;
			"v":  cp = 11'h432;
			"w":  cp = 11'h449;
			"x":  cp = 11'h445;
			"y":  cp = 11'h44B;
			"z":  cp = 11'h437;
			"#":  cp = 11'h44A;
			"'":  cp = 11'h44C;
			"A":  cp = 11'h410;
			"B":  cp = 11'h411;
			"C":  cp = 11'h426;
			"D":  cp = 11'h414;
			"E":  cp = 11'h415;
			"F":  cp = 11'h424;
			"G":  cp = 11'h413;
			"H":  cp = 11'h425;
			"I":  cp = 11'h418;
			"J":  cp = 11'h419;
			"K":  cp = 11'h41A;
			"L":  cp = 11'h41B;
			"M":  cp = 11'h41C;
			"N":  cp = 11'h41D;
			"O":  cp = 11'h41E;
			"P":  cp = 11'h41F;
			"Q":  cp = 11'h42F;
			"R":  cp = 11'h420;
			"S":  cp = 11'h421;
			"T":  cp = 11'h422;
			"U":  cp = 11'h423;
			"V":  cp = 11'h412;
			"W":  cp = 11'h429;
			"X":  cp = 11'h425;
			"Y":  cp = 11'h42B;
			"Z":  cp = 11'h417;
			"\"": cp = 11'h42C;
			default: cp = '0;
		endcase
		return cp;
	endfunction

	// Two-byte keys, first byte in the upper half
	function automatic cp_t lookup2(input byte_t first, input byte_t second);
		cp_t cp;
		case ({first, second})
			"jo": cp = 11'h451;
			"yo": cp = 11'h451;
			"zh": cp = 11'h436;
			"ch": cp = 11'h447;
			"sh": cp = 11'h448;
			"je": cp = 11'h44D;
			"ju": cp = 11'h44E;
			"yu": cp = 11'h44E;
			"ja": cp = 11'h44F;
			"ya": cp = 11'h44F;
			"Jo": cp = 11'h401;
			"Yo": cp = 11'h401;
			"Zh": cp = 11'h416;
			"Ch": cp = 11'h427;
			"Sh": cp = 11'h428;
			"Je": cp = 11'h42D;
			"Ju": cp = 11'h42E;
			"Yu": cp = 11'h42E;
			"Ja": cp = 11'h42F;
			"Ya": cp = 11'h42F;
			"##": cp = 11'h42A;
			default: cp = '0;
		endcase
		return cp;
	endfunction

	// Three-byte keys
	function automatic cp_t lookup3(input byte_t first, input byte_t second,
			input byte_t third);
		cp_t cp;
		case ({first, second, third})
			"shh": cp = 11'h449;
			"Shh": cp = 11'h429;
			default: cp = '0;
		endcase
		return cp;
	endfunction

endpackage

`default_nettype wire

### rtl/latin_to_cyrillic_translit.sv
// ----------------------------------------------------------------------------
// latin_to_cyrillic_translit
// Keystroke-level Latin to Cyrillic transliterator with held key prefix.
// ----------------------------------------------------------------------------
// One result item per input byte. A byte is registered at the input, then
// looked up together with the held key and the result is registered at
// the output; a stall can hold a byte in the input register, and a new
// byte is taken every cycle while the pipeline does not stall. The held key
// is updated as the result is written, which keeps the loop between the
// key ROM compare and the held key registers free of other registers.
// While a result waits, the input register still takes one byte, then stalls.
`default_nettype none

module latin_to_cyrillic_translit
	import ltc_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output      logic              in_stall,
	input  wire logic [BYTE_W-1:0] in_byte,
	output      logic              out_valid,
	input  wire logic              out_stall,
	output      logic [CP_W-1:0]   code_point,
	output      logic [1:0]        action
);

	// Input stage
	logic   valid_s1;
	byte_t  byte_s1;

	// Result stage
	logic    valid_s2;
	cp_t     cp_s2;
	action_t act_s2;

	// Held key (third byte never needs storing: a full key only makes the next byte be looked up alone)
	byte_t             held_b0_q;
	byte_t             held_b1_q;
	logic [LEN_W-1:0]  held_len_q;

	logic advance_s1;
	logic load_s2;

	// Next-state / result logic
	cp_t               cp_ext;
	cp_t               cp_single;
	cp_t               cp_n;
	action_t           act_n;
	byte_t             held_b0_n;
	byte_t             held_b1_n;
	logic [LEN_W-1:0]  held_len_n;

	assign load_s2    = !valid_s2 || !out_stall;
	assign advance_s1 = valid_s1 && load_s2;
	assign in_stall   = valid_s1 && !load_s2;

	// Lookup of held key extended by the new byte, then the byte alone
	always_comb begin
		case (held_len_q)
			2'd0:    cp_ext = lookup1(byte_s1);
			2'd1:    cp_ext = lookup2(held_b0_q, byte_s1);
			2'd2:    cp_ext = lookup3(held_b0_q, held_b1_q, byte_s1);
			default: cp_ext = '0;
		endcase
		cp_single  = lookup1(byte_s1);
		held_b0_n  = held_b0_q;
		held_b1_n  = held_b1_q;
		held_len_n = held_len_q;
		if (cp_ext != '0) begin
			cp_n       = cp_ext;
			act_n      = (held_len_q == 2'd0) ? ACT_ADD : ACT_REPLACE;
			held_len_n = held_len_q + 2'd1;
			if (held_len_q == 2'd0) begin
				held_b0_n = byte_s1;
			end
			if (held_len_q == 2'd1) begin
				held_b1_n = byte_s1;
			end
		end else if (cp_single != '0) begin
			cp_n       = cp_single;
			act_n      = ACT_ADD;
			held_b0_n  = byte_s1;
			held_len_n = 2'd1;
		end else begin
			cp_n       = '0;
			act_n      = ACT_NONE;
			held_len_n = 2'd0;
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			valid_s2   <= 1'b0;
			held_len_q <= '0;
			held_b0_q  <= '0;
			held_b1_q  <= '0;
		end else begin
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			if (load_s2) begin
				valid_s2 <= valid_s1;
			end
			if (advance_s1) begin
				held_len_q <= held_len_n;
				held_b0_q  <= held_b0_n;
				held_b1_q  <= held_b1_n;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			byte_s1 <= in_byte;
		end
		if (advance_s1) begin
			cp_s2  <= cp_n;
			act_s2 <= act_n;
		end
	end

	assign out_valid  = valid_s2;
	assign code_point = cp_s2;
	assign action     = act_s2;

`ifndef SYNTHESIS
	// No translation always carries a zero code point
	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && act_s2 == ACT_NONE) |-> (cp_s2 == '0))
		else $error("no-translation result with non-zero code point");

	// Held key length agrees with the result last written
	a_add_len: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && act_s2 == ACT_ADD) |-> (held_len_q == 2'd1))
		else $error("add result but held key length is not one");

	a_replace_len: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && act_s2 == ACT_REPLACE) |-> (held_len_q == 2'd2 || held_len_q == 2'd3))
		else $error("replace result but held key shorter than two");

	// Input side only stalls on a full pipeline
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2 && out_stall))
		else $error("input stalled with room in the pipeline");
`endif

endmodule

`default_nettype wire
